// ----- src/fpba_pkg.sv -----
// shared types, codes and helpers for the fit policy block allocator
package fpba_pkg;

  localparam int SUM_W = 20;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_ALLOC = 2'd1;
  localparam logic [1:0] STAT_MISS  = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_FIRST = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] size;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       block_index;
    logic [15:0]      block_size;
    logic [15:0]      remaining_after;
    logic [7:0]       request_number;
    logic [SUM_W-1:0] used_total;
    logic [SUM_W-1:0] capacity_total;
  } rsp_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [15:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W-15){1'b0}}, b};
    sat_add = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ----- src/fit_policy_block_allocator.sv -----
// top level of the fit policy block allocator
// The block holds a table of up to MAX_BLOCKS free blocks in two memories
// (remaining and original size) with one write and one read port each, plus a
// used flag per entry. A load, clear or unused word passes through S_EXEC and
// S_DONE before the next word is accepted. An allocation request scans the
// table through one compare unit, reading one entry per cycle from the
// remaining-size memory, then passes through S_DECIDE, S_WB when a block is
// granted, and S_DONE. Only one word is in work at a time; the result
// is held in an output register so a new word can be accepted while the
// previous result waits, and a finished word stalls in its last state until
// that register is free. The policy register may be written while idle.
module fit_policy_block_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_data,
  input  logic           req_valid,
  output logic           req_ready,
  input  fpba_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output fpba_pkg::rsp_t rsp
);
  import fpba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WB     = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]       state;
  logic [1:0]       policy;
  logic [CNT_W-1:0] block_count;
  logic [SUM_W-1:0] granted_sum;
  logic [SUM_W-1:0] loaded_sum;
  logic [7:0]       request_count;
  logic [MAX_BLOCKS-1:0] used_flag;
  logic [CNT_W-1:0] scan_cnt;
  logic             rd_valid;

  logic [SIZE_BITS-1:0] remaining_mem [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] original_mem [MAX_BLOCKS];

  logic [1:0]           cur_type;
  logic [SIZE_BITS-1:0] want;
  logic [15:0]          want16;
  logic [SIZE_BITS-1:0] rd_rem;
  logic                 rd_used;
  logic [IDX_W-1:0]     rd_idx;
  logic [SIZE_BITS-1:0] orig_rd;
  rsp_t                 res;

  logic                 accept;
  logic                 load_out;
  logic                 full;
  logic                 in_scan;
  logic [IDX_W-1:0]     scan_addr;
  logic [SIZE_BITS-1:0] size_m;
  logic [31:0]          size_ext;
  logic                 found;
  logic [IDX_W-1:0]     pick_idx;
  logic [SIZE_BITS-1:0] pick_r;
  logic [SIZE_BITS-1:0] new_rem;
  logic [31:0]          new_rem_ext;
  logic [31:0]          orig_ext;
  logic [31:0]          want_ext;
  logic [31:0]          pick_ext;
  logic [31:0]          cnt_ext;
  logic                 wr_load;
  logic                 wr_alloc;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_rem;
  logic [SUM_W-1:0]     loaded_add;
  logic [SUM_W-1:0]     granted_add;
  rsp_t                 res_exec;
  rsp_t                 res_dec;

  assign accept    = req_valid && req_ready;
  assign req_ready = state == S_IDLE;
  assign load_out  = state == S_DONE && (!rsp_valid || rsp_ready);
  assign full      = block_count >= CNT_W'(MAX_BLOCKS);
  assign in_scan   = state == S_SCAN && scan_cnt < block_count;
  assign scan_addr = scan_cnt[IDX_W-1:0];

  assign size_ext    = 32'(req.size);
  assign size_m      = size_ext[SIZE_BITS-1:0];
  assign new_rem     = pick_r - want;
  assign new_rem_ext = 32'(new_rem);
  assign orig_ext    = 32'(orig_rd);
  assign want_ext    = 32'(want);
  assign pick_ext    = 32'(pick_idx);
  assign cnt_ext     = 32'(block_count);
  assign want16      = want_ext[15:0];

  assign wr_load  = state == S_EXEC && cur_type == REQ_LOAD && !full;
  assign wr_alloc = state == S_DECIDE && found;
  assign wr_addr  = wr_load ? block_count[IDX_W-1:0] : pick_idx;
  assign wr_rem   = wr_load ? want : new_rem;

  assign loaded_add  = sat_add(loaded_sum, want16);
  assign granted_add = sat_add(granted_sum, want16);

  fpba_scan #(
    .SIZE_BITS(SIZE_BITS),
    .IDX_W    (IDX_W)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .en      (rd_valid),
    .policy  (policy),
    .want    (want),
    .r       (rd_rem),
    .used    (rd_used),
    .idx     (rd_idx),
    .found   (found),
    .pick_idx(pick_idx),
    .pick_r  (pick_r)
  );

  always_comb begin
    res_exec                = '0;
    res_exec.status         = STAT_DONE;
    res_exec.request_number = request_count;
    res_exec.used_total     = granted_sum;
    res_exec.capacity_total = loaded_sum;
    case (cur_type)
      REQ_LOAD: begin
        if (full) begin
          res_exec.status = STAT_FULL;
        end else begin
          res_exec.block_index     = cnt_ext[3:0];
          res_exec.block_size      = want16;
          res_exec.remaining_after = want16;
          res_exec.capacity_total  = loaded_add;
        end
      end
      REQ_CLEAR: begin
        res_exec = '0;
      end
      default: begin
        res_exec.request_number = '0;
      end
    endcase
  end

  always_comb begin
    res_dec                = '0;
    res_dec.status         = found ? STAT_ALLOC : STAT_MISS;
    res_dec.request_number = request_count;
    res_dec.used_total     = granted_sum;
    res_dec.capacity_total = loaded_sum;
    if (found) begin
      res_dec.block_index     = pick_ext[3:0];
      res_dec.remaining_after = new_rem_ext[15:0];
      res_dec.used_total      = granted_add;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      policy        <= POL_BEST;
      block_count   <= '0;
      granted_sum   <= '0;
      loaded_sum    <= '0;
      request_count <= '0;
      used_flag     <= '0;
      scan_cnt      <= '0;
      rd_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy <= cfg_data;
      end
      rd_valid <= in_scan;
      case (state)
        S_IDLE: begin
          scan_cnt <= '0;
          if (accept) begin
            state <= (req.req_type == REQ_ALLOC) ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_DONE;
          if (wr_load) begin
            used_flag[wr_addr] <= 1'b0;
            block_count        <= block_count + 1'b1;
            loaded_sum         <= loaded_add;
          end else if (cur_type == REQ_CLEAR) begin
            used_flag     <= '0;
            block_count   <= '0;
            granted_sum   <= '0;
            loaded_sum    <= '0;
            request_count <= '0;
          end
        end
        S_SCAN: begin
          if (in_scan) begin
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (request_count != 8'hFF) begin
            request_count <= request_count + 8'd1;
          end
          if (found) begin
            used_flag[pick_idx] <= 1'b1;
            granted_sum         <= granted_add;
            state               <= S_WB;
          end else begin
            state <= S_DONE;
          end
        end
        S_WB: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_load || wr_alloc) begin
      remaining_mem[wr_addr] <= wr_rem;
    end
    if (wr_load) begin
      original_mem[wr_addr] <= want;
    end
    rd_rem  <= remaining_mem[scan_addr];
    orig_rd <= original_mem[pick_idx];
  end

  always_ff @(posedge clk) begin
    rd_used <= used_flag[scan_addr];
    rd_idx  <= scan_addr;
    if (accept) begin
      cur_type <= req.req_type;
      want     <= size_m;
    end
    case (state)
      S_EXEC:   res <= res_exec;
      S_DECIDE: res <= res_dec;
      S_WB:     res.block_size <= orig_ext[15:0];
      default:  res <= res;
    endcase
    if (load_out) begin
      rsp <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    block_count <= CNT_W'(MAX_BLOCKS))
    else $error("block count past table depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && found) |-> CNT_W'(pick_idx) < block_count)
    else $error("chosen block outside loaded table");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> !req_ready)
    else $error("new word taken while one is in work");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> !rd_valid)
    else $error("table read still in flight at decision");

endmodule

// ----- src/fpba_scan.sv -----
// compare unit that walks the table one entry per cycle and keeps the chosen block
module fpba_scan #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 en,
  input  logic [1:0]           policy,
  input  logic [SIZE_BITS-1:0] want,
  input  logic [SIZE_BITS-1:0] r,
  input  logic                 used,
  input  logic [IDX_W-1:0]     idx,
  output logic                 found,
  output logic [IDX_W-1:0]     pick_idx,
  output logic [SIZE_BITS-1:0] pick_r
);
  import fpba_pkg::*;

  logic fits;
  logic take;

  assign fits = r >= want;

  always_comb begin
    case (policy)
      POL_FIRST: take = fits && !used && !found;
      POL_WORST: take = fits && (!found || r >= pick_r);
      default:   take = fits && (!found || r <= pick_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      found <= 1'b0;
    end else if (en && take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && take) begin
      pick_idx <= idx;
      pick_r   <= r;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    found |-> pick_r >= want)
    else $error("chosen block smaller than request");

  assert property (@(posedge clk) disable iff (rst)
    (found && !start && policy == POL_FIRST) |=> $stable(pick_idx))
    else $error("first fit choice changed");

  assert property (@(posedge clk) disable iff (rst)
    start |=> !found)
    else $error("choice not cleared at start");

endmodule

// ----- test/fpba_checker.sv -----
// checker for the fit policy block allocator: predicts each result word and compares it
module fpba_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_data,
  input  logic           req_valid,
  input  logic           req_ready,
  input  fpba_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  fpba_pkg::rsp_t rsp,
  output int             errors,
  output int             pending,
  output int             checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpba_pkg::*;

  localparam int NBLK = 16;

  logic [1:0]       fit_mode;
  logic [15:0]      left_sz [NBLK];
  logic [15:0]      orig_sz [NBLK];
  logic             taken [NBLK];
  logic [4:0]       nblocks;
  logic [SUM_W-1:0] granted;
  logic [SUM_W-1:0] loaded;
  logic [7:0]       nreq;
  rsp_t             due_results [$];
  rsp_t             oldest;
  int               mism;
  int               seen;

  function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] a,
                                                   input logic [15:0] b);
    logic [SUM_W:0] t;
    t = {1'b0, a} + {{(SUM_W-15){1'b0}}, b};
    return (t > SUM_MAX) ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  function automatic rsp_t allocate_word(input req_t w);
    rsp_t r;
    int pick;
    logic [15:0] best;
    r = '0;
    pick = -1;
    best = '0;
    case (w.req_type)
      REQ_LOAD: begin
        r.request_number = nreq;
        if (nblocks >= NBLK) begin
          r.status = STAT_FULL;
        end else begin
          r.status = STAT_DONE;
          r.block_index = nblocks[3:0];
          left_sz[nblocks] = w.size;
          orig_sz[nblocks] = w.size;
          taken[nblocks] = 1'b0;
          nblocks = nblocks + 5'd1;
          loaded = add_clamped(loaded, w.size);
          r.block_size = w.size;
          r.remaining_after = w.size;
        end
      end
      REQ_ALLOC: begin
        for (int j = 0; j < int'(nblocks); j++) begin
          if (fit_mode == POL_FIRST) begin
            if (pick < 0 && !taken[j] && left_sz[j] >= w.size) pick = j;
          end else if (left_sz[j] >= w.size &&
                       (pick < 0 || (fit_mode == POL_WORST ? left_sz[j] >= best
                                                           : left_sz[j] <= best))) begin
            best = left_sz[j];
            pick = j;
          end
        end
        r.request_number = nreq;
        if (nreq != 8'hFF) nreq = nreq + 8'd1;
        if (pick < 0) begin
          r.status = STAT_MISS;
        end else begin
          left_sz[pick] = left_sz[pick] - w.size;
          taken[pick] = 1'b1;
          granted = add_clamped(granted, w.size);
          r.status = STAT_ALLOC;
          r.block_index = pick[3:0];
          r.block_size = orig_sz[pick];
          r.remaining_after = left_sz[pick];
        end
      end
      REQ_CLEAR: begin
        for (int j = 0; j < NBLK; j++) taken[j] = 1'b0;
        nblocks = '0;
        granted = '0;
        loaded = '0;
        nreq = '0;
      end
      default: begin
      end
    endcase
    r.used_total = granted;
    r.capacity_total = loaded;
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mism++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fit_mode = POL_BEST;
      for (int j = 0; j < NBLK; j++) taken[j] = 1'b0;
      nblocks = '0;
      granted = '0;
      loaded = '0;
      nreq = '0;
      due_results.delete();
    end else begin
      if (cfg_we) fit_mode = cfg_data;
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          $error("result word with no word outstanding");
          mism++;
        end else begin
          oldest = due_results.pop_front();
          check_field("status", oldest.status, rsp.status);
          check_field("block_index", oldest.block_index, rsp.block_index);
          check_field("block_size", oldest.block_size, rsp.block_size);
          check_field("remaining_after", oldest.remaining_after, rsp.remaining_after);
          check_field("request_number", oldest.request_number, rsp.request_number);
          check_field("used_total", oldest.used_total, rsp.used_total);
          check_field("capacity_total", oldest.capacity_total, rsp.capacity_total);
          seen++;
        end
      end
      if (req_valid && req_ready) due_results.push_back(allocate_word(req));
    end
    errors <= mism;
    pending <= due_results.size();
    checked <= seen;
  end

endmodule

// ----- test/fit_policy_block_allocator_tb.sv -----
// testbench top for the fit policy block allocator: stimulus, flow control and verdict
module fit_policy_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpba_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] POL_SPARE  = 2'd3;
  localparam int ITEMS       = 850;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 600000;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_data = '0;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;
  logic       hold_off = 1'b0;
  logic       quiet = 1'b0;

  int errors, pending, checked;
  int n_load, n_alloc, n_clear, n_unused, n_cfg;
  int cycle_cnt;

  fit_policy_block_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  fpba_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles with %0d words outstanding", cycle_cnt, pending);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] kind, input logic [15:0] amount);
    int g;
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) g = 0;
    else if (pick < 88) g = $urandom_range(1, 3);
    else if (pick < 97) g = $urandom_range(4, 10);
    else g = $urandom_range(25, 60);
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{req_type: kind, size: amount};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    case (kind)
      REQ_LOAD:  n_load++;
      REQ_ALLOC: n_alloc++;
      REQ_CLEAR: n_clear++;
      default:   n_unused++;
    endcase
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_policy(input logic [1:0] pol);
    cfg_we <= 1'b1;
    cfg_data <= pol;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  // receiver flow control, with one long hold-off on request
  initial begin
    int run;
    int pick;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_off && !hold_done) begin
        hold_done = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        rsp_ready <= 1'b1;
        run = $urandom_range(1, 12);
      end else if (pick < 85) begin
        rsp_ready <= 1'b0;
        run = $urandom_range(1, 3);
      end else if (pick < 95) begin
        rsp_ready <= 1'b1;
        run = $urandom_range(50, 150);
      end else begin
        rsp_ready <= 1'b0;
        run = $urandom_range(20, 80);
      end
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    int phase;
    int nblk;
    int nreq;
    int szmode;
    int pick;
    bit noisy;
    logic [15:0] cap;
    logic [15:0] amount;
    logic [1:0] pol;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, size extremes, full table, every word kind
    send_word(REQ_ALLOC, 16'd5);
    send_word(REQ_LOAD, 16'd0);
    send_word(REQ_LOAD, 16'hFFFF);
    for (int i = 0; i < 14; i++) send_word(REQ_LOAD, i[0] ? 16'h5555 : (16'hAAAA ^ 16'(i)));
    send_word(REQ_LOAD, 16'd7);
    send_word(REQ_ALLOC, 16'd0);
    send_word(REQ_ALLOC, 16'hFFFF);
    send_word(REQ_ALLOC, 16'd40000);
    send_word(REQ_UNUSED, 16'hFFFF);
    send_word(REQ_CLEAR, 16'hFFFF);

    // random: load a table, then stream requests against it
    phase = 0;
    while (n_load + n_alloc + n_clear < ITEMS) begin
      wait_idle();
      case (phase % 5)
        0: pol = POL_BEST;
        1: pol = POL_FIRST;
        2: pol = POL_WORST;
        3: pol = POL_SPARE;
        default: pol = 2'($urandom_range(0, 3));
      endcase
      write_policy(pol);
      quiet <= ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) != 0) send_word(REQ_CLEAR, 16'($urandom));
      nblk = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 16);
      szmode = $urandom_range(0, 2);
      cap = '0;
      repeat (nblk) begin
        if (szmode == 0) amount = 16'($urandom_range(0, 255));
        else if (szmode == 1) amount = 16'($urandom_range(0, 65535));
        else amount = 16'($urandom_range(1000, 4000));
        if (amount > cap) cap = amount;
        send_word(REQ_LOAD, amount);
      end
      // long phase runs the request counter into saturation under receiver back-pressure
      nreq = (phase == 3) ? 280 : $urandom_range(15, 45);
      noisy = (phase != 3);
      if (phase == 3) hold_off <= 1'b1;
      repeat (nreq) begin
        pick = $urandom_range(0, 99);
        if (noisy && pick < 5) begin
          send_word(2'($urandom_range(0, 3)), 16'($urandom));
        end else begin
          if (pick < 10) amount = '0;
          else if (pick < 14) amount = 16'hFFFF;
          else if (pick < 24) amount = 16'($urandom);
          else if (pick < 60) amount = 16'($urandom_range(0, cap / 4));
          else amount = 16'($urandom_range(0, cap));
          send_word(REQ_ALLOC, amount);
        end
      end
      phase++;
    end

    wait_idle();
    repeat (40) @(posedge clk);
    $display("%0d loads, %0d requests, %0d clears, %0d unused words over %0d policy writes",
             n_load, n_alloc, n_clear, n_unused, n_cfg);
    $display("%0d result words compared, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
